@@ rtl/adam_pkg.sv @@
// ============================================================================
// adam_pkg
// Shared widths, reset values, register indexes and types of the Adam
// update engine.
// ============================================================================
package adam_pkg;

  localparam int DEF_NUM_ELEMENTS = 1024;
  localparam int IDX_W            = 10;
  localparam int GRAD_W           = 32;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 32;
  localparam int STAB_W           = 16;
  localparam int VM_W             = 48;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = 2;
  localparam int DIV_NUM_W        = 80;
  localparam int DIV_DEN_W        = 42;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_SECOND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABILIZER   = 2'd3;

  localparam logic [31:0]       RST_LEARN_RATE   = 32'd42950;
  localparam logic [31:0]       RST_DECAY_FIRST  = 32'd3865470566;
  localparam logic [31:0]       RST_DECAY_SECOND = 32'd4290672329;
  localparam logic [STAB_W-1:0] RST_STABILIZER   = 16'd1;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [GRAD_W-1:0] grad;
    logic              tend;
    logic              in_range;
  } item_t;

  typedef struct packed {
    logic [31:0]       learn_rate;
    logic [31:0]       decay_first;
    logic [31:0]       decay_second;
    logic [STAB_W-1:0] stabilizer;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic                 is_sqrt;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/adam_update_engine.sv @@
// ============================================================================
// adam_update_engine
// Per-element Adam optimizer update in fixed point, with moment stores,
// bias-corrected step and a saturated result.
//
//   channel  handshake                 payload
//   in       in_push / in_full         element index, gradient, tensor end
//   out      out_pop / out_empty       update value, index, tensor end, clip
//   cfg      cfg_valid / cfg_ready     register index, write data
//
// Each item is stepped through the shared multiplier and the shared bit-serial
// divide and square root unit (each division has 80 steps, the root 32); the
// last division is skipped when the bias-corrected first moment or the
// denominator is zero. After reset all NUM_ELEMENTS entries of the moment
// stores are cleared, and in_full stays high meanwhile. A result waits in
// the output register while the input queue keeps taking items.
// ============================================================================
module adam_update_engine #(
  parameter int NUM_ELEMENTS = adam_pkg::DEF_NUM_ELEMENTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [adam_pkg::IDX_W-1:0]      in_element_index,
  input  logic [adam_pkg::GRAD_W-1:0]     in_grad_value,
  input  logic                            in_tensor_end,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [adam_pkg::GRAD_W-1:0]     out_update_value,
  output logic [adam_pkg::IDX_W-1:0]      out_index,
  output logic                            out_tensor_end,
  output logic                            out_clipped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [adam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adam_pkg::CFG_DATA_W-1:0] cfg_data
);
  import adam_pkg::*;

  cfg_t     cfg_r;
  item_t    head;
  logic     avail;
  logic     deq;
  logic     hold;
  div_req_t dreq;
  div_rsp_t drsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learn_rate   <= RST_LEARN_RATE;
      cfg_r.decay_first  <= RST_DECAY_FIRST;
      cfg_r.decay_second <= RST_DECAY_SECOND;
      cfg_r.stabilizer   <= RST_STABILIZER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEARN_RATE:   cfg_r.learn_rate   <= cfg_data;
        REG_DECAY_FIRST:  cfg_r.decay_first  <= cfg_data;
        REG_DECAY_SECOND: cfg_r.decay_second <= cfg_data;
        REG_STABILIZER:   cfg_r.stabilizer   <= cfg_data[STAB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  adam_front #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_element_index (in_element_index),
    .in_grad_value    (in_grad_value),
    .in_tensor_end    (in_tensor_end),
    .hold             (hold),
    .deq              (deq),
    .avail            (avail),
    .head             (head)
  );

  adam_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  adam_back #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .avail            (avail),
    .head             (head),
    .deq              (deq),
    .hold             (hold),
    .dreq             (dreq),
    .drsp             (drsp),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_update_value (out_update_value),
    .out_index        (out_index),
    .out_tensor_end   (out_tensor_end),
    .out_clipped      (out_clipped)
  );

endmodule

@@ rtl/adam_front.sv @@
// ============================================================================
// adam_front
// Input queue of the engine. Accepts items, marks whether the index lies
// inside the moment stores, and holds them until the back end takes them.
// ============================================================================
module adam_front #(
  parameter int NUM_ELEMENTS = adam_pkg::DEF_NUM_ELEMENTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [adam_pkg::IDX_W-1:0] in_element_index,
  input  logic [adam_pkg::GRAD_W-1:0] in_grad_value,
  input  logic                       in_tensor_end,
  input  logic                       hold,
  input  logic                       deq,
  output logic                       avail,
  output adam_pkg::item_t            head
);
  import adam_pkg::*;

  item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              accept;
  logic              take;
  item_t             new_item;

  assign in_full = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH)) || hold;
  assign accept  = in_push && !in_full;
  assign avail   = (cnt_r != '0);
  assign take    = deq && avail;
  assign head    = q_mem[rd_ptr_r];

  always_comb begin
    new_item.idx      = in_element_index;
    new_item.grad     = in_grad_value;
    new_item.tend     = in_tensor_end;
    new_item.in_range = (32'(in_element_index) < NUM_ELEMENTS);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (accept && !take) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (take && !accept) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/adam_divsqrt.sv @@
// ============================================================================
// adam_divsqrt
// Shared iterative unit: restoring division one quotient bit per cycle,
// or integer square root one result bit per cycle.
// ============================================================================
module adam_divsqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  adam_pkg::div_req_t req,
  output adam_pkg::div_rsp_t rsp
);
  import adam_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic                 sqrt_r;
  logic [6:0]           cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] q_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [31:0]          root_r;
  logic [DIV_DEN_W:0]   d_sh;
  logic [35:0]          s_sh;
  logic [35:0]          s_trial;

  assign d_sh    = {rem_r, q_r[DIV_NUM_W-1]};
  assign s_sh    = {rem_r[33:0], q_r[DIV_NUM_W-1 -: 2]};
  assign s_trial = {2'b00, root_r, 2'b01};

  assign rsp.done = done_r;
  assign rsp.quo  = sqrt_r ? DIV_NUM_W'(root_r) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sqrt_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      q_r    <= '0;
      den_r  <= '0;
      root_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        sqrt_r <= req.is_sqrt;
        cnt_r  <= req.is_sqrt ? 7'd31 : 7'(DIV_NUM_W - 1);
        rem_r  <= '0;
        q_r    <= req.num;
        den_r  <= req.den;
        root_r <= '0;
      end else if (busy_r) begin
        if (sqrt_r) begin
          q_r <= {q_r[DIV_NUM_W-3:0], 2'b00};
          if (s_sh >= s_trial) begin
            rem_r  <= DIV_DEN_W'(s_sh - s_trial);
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= DIV_DEN_W'(s_sh);
            root_r <= {root_r[30:0], 1'b0};
          end
        end else begin
          if (d_sh >= {1'b0, den_r}) begin
            rem_r <= DIV_DEN_W'(d_sh - {1'b0, den_r});
            q_r   <= {q_r[DIV_NUM_W-2:0], 1'b1};
          end else begin
            rem_r <= d_sh[DIV_DEN_W-1:0];
            q_r   <= {q_r[DIV_NUM_W-2:0], 1'b0};
          end
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/adam_back.sv @@
// ============================================================================
// adam_back
// Back end of the engine. Holds the moment stores and the decay powers,
// steps one item through a shared multiplier and the divide and root unit,
// and keeps the finished result in an output register.
// ============================================================================
module adam_back #(
  parameter int NUM_ELEMENTS = adam_pkg::DEF_NUM_ELEMENTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  adam_pkg::cfg_t              cfg,
  input  logic                        avail,
  input  adam_pkg::item_t             head,
  output logic                        deq,
  output logic                        hold,
  output adam_pkg::div_req_t          dreq,
  input  adam_pkg::div_rsp_t          drsp,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [adam_pkg::GRAD_W-1:0] out_update_value,
  output logic [adam_pkg::IDX_W-1:0]  out_index,
  output logic                        out_tensor_end,
  output logic                        out_clipped
);
  import adam_pkg::*;

  localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_M1   = 5'd3;
  localparam logic [4:0] S_M2   = 5'd4;
  localparam logic [4:0] S_M3   = 5'd5;
  localparam logic [4:0] S_V1   = 5'd6;
  localparam logic [4:0] S_V2   = 5'd7;
  localparam logic [4:0] S_V3   = 5'd8;
  localparam logic [4:0] S_V4   = 5'd9;
  localparam logic [4:0] S_V5   = 5'd10;
  localparam logic [4:0] S_P1   = 5'd11;
  localparam logic [4:0] S_P2   = 5'd12;
  localparam logic [4:0] S_D1W  = 5'd13;
  localparam logic [4:0] S_D2   = 5'd14;
  localparam logic [4:0] S_D2W  = 5'd15;
  localparam logic [4:0] S_SQ   = 5'd16;
  localparam logic [4:0] S_SQW  = 5'd17;
  localparam logic [4:0] S_MU   = 5'd18;
  localparam logic [4:0] S_D3   = 5'd19;
  localparam logic [4:0] S_D3W  = 5'd20;
  localparam logic [4:0] S_FIN  = 5'd21;

  logic [31:0]      fm_mem [NUM_ELEMENTS];
  logic [VM_W-1:0]  sm_mem [NUM_ELEMENTS];
  logic [31:0]      fm_rd_r;
  logic [VM_W-1:0]  sm_rd_r;

  logic [4:0]       state_r;
  logic [4:0]       state_nxt;
  logic [AW-1:0]    clr_cnt_r;
  item_t            it_r;
  logic [AW-1:0]    addr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [31:0]      fm_wdata;
  logic [VM_W-1:0]  sm_wdata;

  logic signed [33:0] opa;
  logic signed [33:0] opb;
  logic signed [67:0] mul_p_r;
  logic signed [81:0] acc_r;
  logic signed [81:0] p_ext;
  logic signed [81:0] rsum;

  logic [31:0]      m_old;
  logic [VM_W-1:0]  v_old;
  logic [31:0]      gmag;
  logic [32:0]      om1;
  logic [32:0]      om2;
  logic [31:0]      m_r;
  logic [VM_W-1:0]  gsq_r;
  logic [VM_W:0]    vsum_r;
  logic [VM_W-1:0]  v_r;
  logic [VM_W-1:0]  v_new;
  logic [31:0]      pow1_r;
  logic [31:0]      pow2_r;
  logic [31:0]      pw1_r;
  logic [31:0]      pw2_r;
  logic [30:0]      mh_r;
  logic [VM_W-1:0]  vh_r;
  logic [32:0]      den_r;
  logic [31:0]      u_r;
  logic             sat_r;
  logic             neg;
  logic [31:0]      mmag;
  logic [31:0]      lim3;
  logic             load_out;
  logic             out_full_r;

  assign addr  = AW'(it_r.idx);
  assign m_old = it_r.in_range ? fm_rd_r : '0;
  assign v_old = it_r.in_range ? sm_rd_r : '0;
  assign gmag  = it_r.grad[31] ? (32'd0 - it_r.grad) : it_r.grad;
  assign om1   = 33'h1_0000_0000 - {1'b0, cfg.decay_first};
  assign om2   = 33'h1_0000_0000 - {1'b0, cfg.decay_second};
  assign neg   = !m_r[31] && (m_r != '0);
  assign mmag  = m_r[31] ? (32'd0 - m_r) : m_r;
  assign lim3  = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign p_ext = {{14{mul_p_r[67]}}, mul_p_r};
  assign rsum  = acc_r + p_ext + 82'sh8000_0000;
  assign v_new = VM_W'(vsum_r + rsum[80:32]);

  assign hold      = (state_r == S_CLR);
  assign deq       = (state_r == S_IDLE) && avail;
  assign load_out  = (state_r == S_FIN) && (!out_full_r || out_pop);
  assign out_empty = !out_full_r;

  assign mem_we    = (state_r == S_CLR) || ((state_r == S_V5) && it_r.in_range);
  assign mem_waddr = (state_r == S_CLR) ? clr_cnt_r : addr;
  assign fm_wdata  = (state_r == S_CLR) ? '0 : m_r;
  assign sm_wdata  = (state_r == S_CLR) ? '0 : v_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fm_mem[mem_waddr] <= fm_wdata;
      sm_mem[mem_waddr] <= sm_wdata;
    end
    fm_rd_r <= fm_mem[addr];
    sm_rd_r <= sm_mem[addr];
  end

  always_comb begin
    opa = '0;
    opb = '0;
    case (state_r)
      S_M1: begin
        opa = {{2{m_old[31]}}, m_old};
        opb = {2'b00, cfg.decay_first};
      end
      S_M2: begin
        opa = {{2{it_r.grad[31]}}, it_r.grad};
        opb = {1'b0, om1};
      end
      S_M3: begin
        opa = {2'b00, gmag};
        opb = {2'b00, gmag};
      end
      S_V1: begin
        opa = {10'd0, v_old[47:24]};
        opb = {2'b00, cfg.decay_second};
      end
      S_V2: begin
        opa = {10'd0, v_old[23:0]};
        opb = {2'b00, cfg.decay_second};
      end
      S_V3: begin
        opa = {10'd0, gsq_r[47:24]};
        opb = {1'b0, om2};
      end
      S_V4: begin
        opa = {10'd0, gsq_r[23:0]};
        opb = {1'b0, om2};
      end
      S_V5: begin
        opa = {2'b00, pow1_r};
        opb = {2'b00, cfg.decay_first};
      end
      S_P1: begin
        opa = {2'b00, pow2_r};
        opb = {2'b00, cfg.decay_second};
      end
      S_MU: begin
        opa = {2'b00, cfg.learn_rate};
        opb = {3'b000, mh_r};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    dreq.start   = 1'b0;
    dreq.is_sqrt = 1'b0;
    dreq.num     = '0;
    dreq.den     = '0;
    case (state_r)
      S_P2: begin
        dreq.start = 1'b1;
        dreq.num   = {16'd0, mmag, 32'd0};
        dreq.den   = {9'd0, 33'h1_0000_0000 - {1'b0, pw1_r}};
      end
      S_D2: begin
        dreq.start = 1'b1;
        dreq.num   = {v_r, 32'd0};
        dreq.den   = {9'd0, 33'h1_0000_0000 - {1'b0, pw2_r}};
      end
      S_SQ: begin
        dreq.start   = 1'b1;
        dreq.is_sqrt = 1'b1;
        dreq.num     = {vh_r, 32'd0};
      end
      S_D3: begin
        dreq.start = 1'b1;
        dreq.num   = {16'd0, mul_p_r[63:0]};
        dreq.den   = {1'b0, den_r, 8'd0};
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  state_nxt = (clr_cnt_r == AW'(NUM_ELEMENTS - 1)) ? S_IDLE : S_CLR;
      S_IDLE: state_nxt = avail ? S_RD : S_IDLE;
      S_RD:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_V1;
      S_V1:   state_nxt = S_V2;
      S_V2:   state_nxt = S_V3;
      S_V3:   state_nxt = S_V4;
      S_V4:   state_nxt = S_V5;
      S_V5:   state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_D1W;
      S_D1W:  state_nxt = drsp.done ? S_D2 : S_D1W;
      S_D2:   state_nxt = S_D2W;
      S_D2W:  state_nxt = drsp.done ? S_SQ : S_D2W;
      S_SQ:   state_nxt = S_SQW;
      S_SQW:  state_nxt = drsp.done ? S_MU : S_SQW;
      S_MU:   state_nxt = ((mh_r == '0) || (den_r == '0)) ? S_FIN : S_D3;
      S_D3:   state_nxt = S_D3W;
      S_D3W:  state_nxt = drsp.done ? S_FIN : S_D3W;
      S_FIN:  state_nxt = load_out ? S_IDLE : S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_cnt_r  <= '0;
      out_full_r <= 1'b0;
      pow1_r     <= '1;
      pow2_r     <= '1;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (load_out) begin
        out_full_r <= 1'b1;
        if (it_r.tend) begin
          pow1_r <= pw1_r;
          pow2_r <= pw2_r;
        end
      end else if (out_pop && out_full_r) begin
        out_full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= opa * opb;
    case (state_r)
      S_IDLE: begin
        it_r  <= head;
        sat_r <= 1'b0;
      end
      S_M2: acc_r <= p_ext;
      S_M3: begin
        m_r <= rsum[63:32];
      end
      S_V1: gsq_r <= mul_p_r[63:16];
      S_V2: acc_r <= {mul_p_r[57:0], 24'd0};
      S_V3: vsum_r <= rsum[80:32];
      S_V4: acc_r <= {mul_p_r[57:0], 24'd0};
      S_V5: v_r <= v_new;
      S_P1: pw1_r <= 32'(({1'b0, mul_p_r[63:0]} + 65'h8000_0000) >> 32);
      S_P2: pw2_r <= 32'(({1'b0, mul_p_r[63:0]} + 65'h8000_0000) >> 32);
      S_D1W: begin
        if (drsp.done) begin
          if (drsp.quo > 80'h7FFF_FFFF) begin
            mh_r  <= '1;
            sat_r <= 1'b1;
          end else begin
            mh_r <= drsp.quo[30:0];
          end
        end
      end
      S_D2W: begin
        if (drsp.done) begin
          if (drsp.quo[79:48] != '0) begin
            vh_r  <= '1;
            sat_r <= 1'b1;
          end else begin
            vh_r <= drsp.quo[47:0];
          end
        end
      end
      S_SQW: begin
        if (drsp.done) begin
          den_r <= {1'b0, drsp.quo[31:0]} + {17'd0, cfg.stabilizer};
        end
      end
      S_MU: begin
        if (mh_r == '0) begin
          u_r <= '0;
        end else if (den_r == '0) begin
          u_r   <= lim3;
          sat_r <= 1'b1;
        end
      end
      S_D3W: begin
        if (drsp.done) begin
          if (drsp.quo > {48'd0, lim3}) begin
            u_r   <= lim3;
            sat_r <= 1'b1;
          end else begin
            u_r <= drsp.quo[31:0];
          end
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_update_value <= neg ? (32'd0 - u_r) : u_r;
      out_index        <= it_r.idx;
      out_tensor_end   <= it_r.tend;
      out_clipped      <= sat_r;
    end
  end

endmodule
